>>> rtl/core/line_sensor_steering_pid_defines.svh
// ----------------------------------------------------------------------------
// line_sensor_steering_pid_defines.svh
// Assertion macros shared by the checker of the steering block.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_STEERING_PID_DEFINES_SVH
`define LINE_SENSOR_STEERING_PID_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSSP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line_sensor_steering_pid: check failed");

// Consequent checked in the cycle after the antecedent.
`define LSSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line_sensor_steering_pid: check failed");

`endif

>>> rtl/core/lssp_pkg.sv
// ----------------------------------------------------------------------------
// lssp_pkg
// Types, constants and helper functions of the line sensor steering block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lssp_pkg;

   localparam int NUM_LAMPS_DEF = 8;

   localparam int HEAD_W     = 15;
   localparam int GAIN_W     = 16;
   localparam int STEP_W     = 13;
   localparam int SPEED_W    = 13;
   localparam int LIN_W      = 13;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAMP_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_SPEED = 3'd4;

   localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd1229;
   localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd2458;
   localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd205;
   localparam logic [STEP_W-1:0]  LAMP_STEP_RST   = 13'd646;
   localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST = 13'd410;
   localparam logic [SPEED_W-1:0] SPEED_MAX       = 13'd4096;

   // Shared multiplier and accumulator widths.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;

   // floor(x / 3) == (x * RECIP3) >> RECIP_SHIFT for every x below 2**21.
   localparam logic signed [MUL_B_W-1:0] RECIP3 = 21'sd699051;
   localparam int RECIP_SHIFT = 21;

   localparam int FRAC_BITS = 12;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd2048);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

   // Waypoint aim headings and open windows, Q3.12 radians.
   localparam logic signed [15:0] WP0_AIM = 16'sd4370;
   localparam logic signed [15:0] WP0_LO  = 16'sd2048;
   localparam logic signed [15:0] WP0_HI  = 16'sd6144;
   localparam logic signed [15:0] WP1_AIM = -16'sd8741;
   localparam logic signed [15:0] WP1_LO  = -16'sd9421;
   localparam logic signed [15:0] WP1_HI  = -16'sd7782;
   localparam logic signed [15:0] WP2_AIM = -16'sd4370;
   localparam logic signed [15:0] WP2_LO  = -16'sd4452;
   localparam logic signed [15:0] WP2_HI  = -16'sd4289;
   localparam logic signed [15:0] WP3_AIM = 16'sd0;
   localparam logic signed [15:0] WP3_LO  = -16'sd193;
   localparam logic signed [15:0] WP3_HI  = 16'sd193;

   typedef enum logic [1:0] {
      LEG_FIRST,
      LEG_SECOND,
      LEG_THIRD,
      LEG_FOURTH
   } leg_type;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_ctrl_type;

   typedef struct packed {
      logic              stop;
      logic              centroid;
      logic              count_two;
      logic              count_three;
      logic signed [15:0] wp_target;
      leg_type           wp_leg;
   } tgt_info_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/lssp_if.sv
// ----------------------------------------------------------------------------
// lssp_if
// Request, response and register write channels of the steering block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lssp_req_if #(
   parameter int NUM_LAMPS = lssp_pkg::NUM_LAMPS_DEF
) ();
   logic                                valid;
   logic                                ready;
   logic [NUM_LAMPS-1:0]                lamp_bits;
   logic signed [lssp_pkg::HEAD_W-1:0]  heading;

   modport source (output valid, lamp_bits, heading, input ready);
   modport sink   (input valid, lamp_bits, heading, output ready);
endinterface

interface lssp_rsp_if ();
   logic                                valid;
   logic                                ready;
   logic                                driving;
   logic signed [lssp_pkg::LIN_W-1:0]   linear_cmd;
   logic signed [lssp_pkg::DATA_W-1:0]  angular_cmd;
   logic [1:0]                          waypoint_leg;

   modport source (output valid, driving, linear_cmd, angular_cmd, waypoint_leg, input ready);
   modport sink   (input valid, driving, linear_cmd, angular_cmd, waypoint_leg, output ready);
endinterface

interface lssp_csr_if ();
   logic                                valid;
   logic                                ready;
   logic [lssp_pkg::CSR_IDX_W-1:0]      index;
   logic [lssp_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/lssp_mac.sv
// ----------------------------------------------------------------------------
// lssp_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lssp_mac (
   input  logic                                  clock,
   input  lssp_pkg::mac_ctrl_type                ctrl,
   input  logic signed [lssp_pkg::MUL_A_W-1:0]   op_a,
   input  logic signed [lssp_pkg::MUL_B_W-1:0]   op_b,
   output logic signed [lssp_pkg::PROD_W-1:0]    prod,
   output logic signed [lssp_pkg::ACC_W-1:0]     acc
);

   logic signed [lssp_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [lssp_pkg::ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (ctrl.mul_en) begin
         prod_in = op_a * op_b;
      end
      // The accumulator always takes the registered product, not the one being formed.
      if (ctrl.acc_load) begin
         acc_in = lssp_pkg::ACC_W'(prod_ff);
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + lssp_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

>>> rtl/core/lssp_target.sv
// ----------------------------------------------------------------------------
// lssp_target
// Lamp count, lamp weight sum and waypoint leg target for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lssp_target #(
   parameter int NUM_LAMPS = lssp_pkg::NUM_LAMPS_DEF,
   parameter int SUM_W     = $clog2(NUM_LAMPS * NUM_LAMPS / 4 + 1) + 1
) (
   input  logic [NUM_LAMPS-1:0]                lamp_bits,
   input  logic signed [lssp_pkg::HEAD_W-1:0]  heading,
   input  lssp_pkg::leg_type                   leg,
   output lssp_pkg::tgt_info_type              info,
   output logic signed [SUM_W-1:0]             lamp_sum
);

   localparam int CNT_W = $clog2(NUM_LAMPS + 1);

   logic [CNT_W-1:0]        count;
   logic signed [SUM_W-1:0] sum;
   logic signed [15:0]      head;

   // Lamp j weighs NUM_LAMPS-1-2j half steps.
   always_comb begin
      count = '0;
      sum   = '0;
      for (int j = 0; j < NUM_LAMPS; j++) begin
         if (lamp_bits[j]) begin
            count = count + CNT_W'(1);
            sum   = sum + SUM_W'(NUM_LAMPS - 1 - 2 * j);
         end
      end
   end

   assign lamp_sum = sum;
   assign head     = {heading[lssp_pkg::HEAD_W-1], heading};

   always_comb begin
      info.stop        = (count == '0) || (count == CNT_W'(NUM_LAMPS));
      info.centroid    = !info.stop && (count <= CNT_W'(3));
      info.count_two   = (count == CNT_W'(2));
      info.count_three = (count == CNT_W'(3));
      info.wp_leg      = leg;
      case (leg)
         lssp_pkg::LEG_FIRST: begin
            info.wp_target = lssp_pkg::WP0_AIM - head;
            if (head > lssp_pkg::WP0_LO && head < lssp_pkg::WP0_HI) begin
               info.wp_leg = lssp_pkg::LEG_SECOND;
            end
         end
         lssp_pkg::LEG_SECOND: begin
            info.wp_target = lssp_pkg::WP1_AIM - head;
            if (head > lssp_pkg::WP1_LO && head < lssp_pkg::WP1_HI) begin
               info.wp_leg = lssp_pkg::LEG_THIRD;
            end
         end
         lssp_pkg::LEG_THIRD: begin
            info.wp_target = lssp_pkg::WP2_AIM - head;
            if (head > lssp_pkg::WP2_LO && head < lssp_pkg::WP2_HI) begin
               info.wp_leg = lssp_pkg::LEG_FOURTH;
            end
         end
         default: begin
            info.wp_target = lssp_pkg::WP3_AIM - head;
            if (head > lssp_pkg::WP3_LO && head < lssp_pkg::WP3_HI) begin
               info.wp_leg = lssp_pkg::LEG_FIRST;
            end
         end
      endcase
   end

endmodule

>>> rtl/core/line_sensor_steering_pid.sv
// ----------------------------------------------------------------------------
// line_sensor_steering_pid
// A request passes S_WSUM, S_SCALE, S_ERR, S_INTEG, S_MULI, S_MULD, S_ACC and
// S_OUT, which holds while a result waits; requests are taken only in S_IDLE.
// The single shared multiplier forms the centroid weight, the divide by three
// and the three PID terms. Reset clears the PID state, the leg and the output
// valid and loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_sensor_steering_pid #(
   parameter int NUM_LAMPS = lssp_pkg::NUM_LAMPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lssp_req_if.sink    req_bus,
   lssp_rsp_if.source  rsp_bus,
   lssp_csr_if.sink    csr_bus
);

   localparam int SUM_W  = $clog2(NUM_LAMPS * NUM_LAMPS / 4 + 1) + 1;
   localparam int WSUM_W = lssp_pkg::STEP_W + SUM_W;
   localparam int A_W    = lssp_pkg::MUL_A_W;
   localparam int B_W    = lssp_pkg::MUL_B_W;
   localparam int D_W    = lssp_pkg::DATA_W;
   localparam int ACC_W  = lssp_pkg::ACC_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WSUM,
      S_SCALE,
      S_ERR,
      S_INTEG,
      S_MULI,
      S_MULD,
      S_ACC,
      S_OUT
   } state_type;

   state_type                        state_ff, state_in;
   logic [NUM_LAMPS-1:0]             lamp_ff, lamp_in;
   logic signed [lssp_pkg::HEAD_W-1:0] head_ff, head_in;

   logic [lssp_pkg::GAIN_W-1:0]      gain_p_ff, gain_p_in;
   logic [lssp_pkg::GAIN_W-1:0]      gain_i_ff, gain_i_in;
   logic [lssp_pkg::GAIN_W-1:0]      gain_d_ff, gain_d_in;
   logic [lssp_pkg::STEP_W-1:0]      lamp_step_ff, lamp_step_in;
   logic [lssp_pkg::SPEED_W-1:0]     drive_speed_ff, drive_speed_in;

   logic                             sign_ff, sign_in;
   logic [WSUM_W-1:0]                shift_ff, shift_in;
   logic signed [D_W-1:0]            err_ff, err_in;
   logic signed [D_W-1:0]            integ_ff, integ_in;
   logic signed [D_W:0]              diff_ff, diff_in;
   logic                             drive_ff, drive_in;

   logic signed [D_W-1:0]            integral_ff, integral_in;
   logic signed [D_W-1:0]            prev_err_ff, prev_err_in;
   logic signed [D_W-1:0]            prev_out_ff, prev_out_in;
   lssp_pkg::leg_type                leg_ff, leg_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_driving_ff, rsp_driving_in;
   logic signed [lssp_pkg::LIN_W-1:0] rsp_lin_ff, rsp_lin_in;
   logic signed [D_W-1:0]            rsp_ang_ff, rsp_ang_in;
   lssp_pkg::leg_type                rsp_leg_ff, rsp_leg_in;

   lssp_pkg::tgt_info_type           info;
   logic signed [SUM_W-1:0]          lamp_sum;
   lssp_pkg::mac_ctrl_type           mac_ctrl;
   logic signed [A_W-1:0]            mac_a;
   logic signed [B_W-1:0]            mac_b;
   logic signed [lssp_pkg::PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]          acc;

   logic signed [WSUM_W-1:0]         wsum;
   logic [WSUM_W-1:0]                mag;
   logic [WSUM_W-1:0]                shift_c;
   logic [WSUM_W-1:0]                quot;
   logic signed [A_W-1:0]            cent_ext;
   logic signed [A_W-1:0]            target;
   logic signed [A_W-1:0]            err_wide;
   logic signed [ACC_W-1:0]          rounded;
   logic signed [D_W-1:0]            pid_out;
   logic [lssp_pkg::SPEED_W-1:0]     speed;
   logic                             out_free;

   lssp_target #(
      .NUM_LAMPS (NUM_LAMPS),
      .SUM_W     (SUM_W)
   ) u_target (
      .lamp_bits (lamp_ff),
      .heading   (head_ff),
      .leg       (leg_ff),
      .info      (info),
      .lamp_sum  (lamp_sum)
   );

   lssp_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .prod  (prod),
      .acc   (acc)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Centroid: |wsum| / (2 * count) truncated, a divide by three going through
   // the multiplier as a reciprocal.
   assign wsum     = prod[WSUM_W-1:0];
   assign mag      = wsum[WSUM_W-1] ? WSUM_W'(-wsum) : WSUM_W'(wsum);
   assign shift_c  = info.count_two ? (mag >> 2) : (mag >> 1);
   assign quot     = info.count_three ? prod[lssp_pkg::RECIP_SHIFT +: WSUM_W] : shift_ff;
   assign cent_ext = {{(A_W - WSUM_W){1'b0}}, quot};

   always_comb begin
      if (info.stop) begin
         target = '0;
      end else if (info.centroid) begin
         target = sign_ff ? -cent_ext : cent_ext;
      end else begin
         target = {{(A_W - 16){info.wp_target[15]}}, info.wp_target};
      end
   end

   assign err_wide = target - A_W'(prev_out_ff);
   assign rounded  = acc + lssp_pkg::ROUND_HALF;
   assign pid_out  = lssp_pkg::sat32(rounded >>> lssp_pkg::FRAC_BITS);
   assign speed    = (drive_speed_ff > lssp_pkg::SPEED_MAX) ? lssp_pkg::SPEED_MAX
                                                           : drive_speed_ff;

   always_comb begin
      state_in       = state_ff;
      lamp_in        = lamp_ff;
      head_in        = head_ff;
      gain_p_in      = gain_p_ff;
      gain_i_in      = gain_i_ff;
      gain_d_in      = gain_d_ff;
      lamp_step_in   = lamp_step_ff;
      drive_speed_in = drive_speed_ff;
      sign_in        = sign_ff;
      shift_in       = shift_ff;
      err_in         = err_ff;
      integ_in       = integ_ff;
      diff_in        = diff_ff;
      drive_in       = drive_ff;
      integral_in    = integral_ff;
      prev_err_in    = prev_err_ff;
      prev_out_in    = prev_out_ff;
      leg_in         = leg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_driving_in = rsp_driving_ff;
      rsp_lin_in     = rsp_lin_ff;
      rsp_ang_in     = rsp_ang_ff;
      rsp_leg_in     = rsp_leg_ff;
      mac_ctrl       = '0;
      mac_a          = '0;
      mac_b          = '0;

      if (csr_bus.valid) begin
         case (csr_bus.index)
            lssp_pkg::CSR_GAIN_P:      gain_p_in      = csr_bus.data;
            lssp_pkg::CSR_GAIN_I:      gain_i_in      = csr_bus.data;
            lssp_pkg::CSR_GAIN_D:      gain_d_in      = csr_bus.data;
            lssp_pkg::CSR_LAMP_STEP:   lamp_step_in   = csr_bus.data[lssp_pkg::STEP_W-1:0];
            lssp_pkg::CSR_DRIVE_SPEED: drive_speed_in = csr_bus.data[lssp_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               lamp_in  = req_bus.lamp_bits;
               head_in  = req_bus.heading;
               state_in = S_WSUM;
            end
         end
         S_WSUM: begin
            mac_ctrl.mul_en = 1'b1;
            mac_a    = {{(A_W - lssp_pkg::STEP_W){1'b0}}, lamp_step_ff};
            mac_b    = B_W'(lamp_sum);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            mac_ctrl.mul_en = 1'b1;
            mac_a    = {{(A_W - WSUM_W){1'b0}}, shift_c};
            mac_b    = lssp_pkg::RECIP3;
            sign_in  = wsum[WSUM_W-1];
            shift_in = shift_c;
            state_in = S_ERR;
         end
         S_ERR: begin
            err_in   = lssp_pkg::sat32(ACC_W'(err_wide));
            drive_in = !info.stop;
            if (!info.stop && !info.centroid) begin
               leg_in = info.wp_leg;
            end
            state_in = S_INTEG;
         end
         S_INTEG: begin
            integ_in = lssp_pkg::sat32(ACC_W'(integral_ff) + ACC_W'(err_ff));
            diff_in  = (D_W + 1)'(err_ff) - (D_W + 1)'(prev_err_ff);
            mac_ctrl.mul_en = 1'b1;
            mac_a    = A_W'(err_ff);
            mac_b    = {{(B_W - lssp_pkg::GAIN_W){1'b0}}, gain_p_ff};
            state_in = S_MULI;
         end
         S_MULI: begin
            mac_ctrl.mul_en   = 1'b1;
            mac_ctrl.acc_load = 1'b1;
            mac_a    = A_W'(integ_ff);
            mac_b    = {{(B_W - lssp_pkg::GAIN_W){1'b0}}, gain_i_ff};
            state_in = S_MULD;
         end
         S_MULD: begin
            mac_ctrl.mul_en  = 1'b1;
            mac_ctrl.acc_add = 1'b1;
            mac_a    = A_W'(diff_ff);
            mac_b    = {{(B_W - lssp_pkg::GAIN_W){1'b0}}, gain_d_ff};
            state_in = S_ACC;
         end
         S_ACC: begin
            mac_ctrl.acc_add = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold here while the previous result still waits to be taken.
            if (out_free) begin
               integral_in    = integ_ff;
               prev_err_in    = err_ff;
               prev_out_in    = pid_out;
               rsp_valid_in   = 1'b1;
               rsp_driving_in = drive_ff;
               rsp_lin_in     = drive_ff ? (lssp_pkg::LIN_W'(0) - speed) : '0;
               rsp_ang_in     = drive_ff ? pid_out : '0;
               rsp_leg_in     = leg_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         gain_p_ff      <= lssp_pkg::GAIN_P_RST;
         gain_i_ff      <= lssp_pkg::GAIN_I_RST;
         gain_d_ff      <= lssp_pkg::GAIN_D_RST;
         lamp_step_ff   <= lssp_pkg::LAMP_STEP_RST;
         drive_speed_ff <= lssp_pkg::DRIVE_SPEED_RST;
         integral_ff    <= '0;
         prev_err_ff    <= '0;
         prev_out_ff    <= '0;
         leg_ff         <= lssp_pkg::LEG_FIRST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gain_p_ff      <= gain_p_in;
         gain_i_ff      <= gain_i_in;
         gain_d_ff      <= gain_d_in;
         lamp_step_ff   <= lamp_step_in;
         drive_speed_ff <= drive_speed_in;
         integral_ff    <= integral_in;
         prev_err_ff    <= prev_err_in;
         prev_out_ff    <= prev_out_in;
         leg_ff         <= leg_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      lamp_ff        <= lamp_in;
      head_ff        <= head_in;
      sign_ff        <= sign_in;
      shift_ff       <= shift_in;
      err_ff         <= err_in;
      integ_ff       <= integ_in;
      diff_ff        <= diff_in;
      drive_ff       <= drive_in;
      rsp_driving_ff <= rsp_driving_in;
      rsp_lin_ff     <= rsp_lin_in;
      rsp_ang_ff     <= rsp_ang_in;
      rsp_leg_ff     <= rsp_leg_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.driving      = rsp_driving_ff;
   assign rsp_bus.linear_cmd   = rsp_lin_ff;
   assign rsp_bus.angular_cmd  = rsp_ang_ff;
   assign rsp_bus.waypoint_leg = rsp_leg_ff;

endmodule

>>> rtl/core/lssp_checker.sv
// ----------------------------------------------------------------------------
// lssp_checker
// Port level checks of the steering block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_sensor_steering_pid_defines.svh"

module lssp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_driving,
   input logic signed [lssp_pkg::LIN_W-1:0]   rsp_linear_cmd,
   input logic signed [lssp_pkg::DATA_W-1:0]  rsp_angular_cmd
);

   // A stalled result keeps its valid and its angular command.
   `LSSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_angular_cmd))

   // The block works on one item at a time.
   `LSSP_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

   // A stopped result commands no motion.
   `LSSP_ASSERT_SAME(a_stop_zero, rsp_valid && !rsp_driving, rsp_linear_cmd == 0 && rsp_angular_cmd == 0)

   // The linear command is never positive.
   `LSSP_ASSERT_SAME(a_lin_sign, rsp_valid, rsp_linear_cmd == 0 || rsp_linear_cmd[lssp_pkg::LIN_W-1])

endmodule

bind line_sensor_steering_pid lssp_checker u_lssp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_driving     (rsp_bus.driving),
   .rsp_linear_cmd  (rsp_bus.linear_cmd),
   .rsp_angular_cmd (rsp_bus.angular_cmd)
);

>>> tb/sv/line_sensor_steering_pid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_steering_pid_tb
// Self-checking bench for the line sensor steering block. A directed table of
// lamp patterns and headings walks every target case and every waypoint leg.
// Random traffic then follows under several gain, lamp spacing and speed
// settings. Each response is checked field by field against a cycle-free
// model of the lamp count, the centroid, the waypoint legs and the PID loop.
// ----------------------------------------------------------------------------

module line_sensor_steering_pid_tb;
   import lssp_pkg::*;

   localparam int PERIOD       = 8;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 230;
   localparam int DIR_ROWS     = 24;

   typedef struct packed {
      logic               driving;
      logic        [12:0] linear;
      logic signed [31:0] angular;
      logic        [1:0]  leg;
   } steer_result_t;

   typedef struct packed {
      logic [7:0]    lamps;
      logic [14:0]   head;
      logic          typed;
      steer_result_t exp;
   } dir_row_t;

   logic clock;
   logic reset;

   lssp_req_if req_if ();
   lssp_rsp_if rsp_if ();
   lssp_csr_if csr_if ();

   line_sensor_steering_pid dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Model copy of the registers and the loop state.
   logic [15:0]        kp;
   logic [15:0]        ki;
   logic [15:0]        kd;
   logic [12:0]        lamp_pitch;
   logic [12:0]        speed_set;
   logic signed [31:0] pid_integral;
   logic signed [31:0] pid_last_err;
   logic signed [31:0] pid_last_out;
   leg_type            wp_leg;

   steer_result_t expected_q[$];
   int            error_count = 0;
   int            burst_left = 0;
   bit            hold_request = 0;

   // Only the first rows, taken straight after reset, have a typed result.
   dir_row_t dir_rows [DIR_ROWS] = '{
      '{8'h00, 15'sd0,     1'b1, '{1'b0, 13'd0, 32'sd0, LEG_FIRST}},
      '{8'hFF, 15'h4000,   1'b1, '{1'b0, 13'd0, 32'sd0, LEG_FIRST}},
      '{8'h00, 15'h3FFF,   1'b1, '{1'b0, 13'd0, 32'sd0, LEG_FIRST}},
      '{8'h01, 15'sd0,     1'b0, '0},
      '{8'h80, 15'sd0,     1'b0, '0},
      '{8'h03, 15'sd0,     1'b0, '0},
      '{8'h07, 15'sd100,   1'b0, '0},
      '{8'hE0, -15'sd100,  1'b0, '0},
      '{8'h81, 15'sd0,     1'b0, '0},
      '{8'h18, 15'sd0,     1'b0, '0},
      '{8'h0F, 15'sd2048,  1'b0, '0},
      '{8'h1F, 15'sd6144,  1'b0, '0},
      '{8'h3F, 15'sd4000,  1'b0, '0},
      '{8'h7F, 15'h4000,   1'b0, '0},
      '{8'hFE, -15'sd9421, 1'b0, '0},
      '{8'hF0, -15'sd8000, 1'b0, '0},
      '{8'h3C, -15'sd4452, 1'b0, '0},
      '{8'h0F, -15'sd4370, 1'b0, '0},
      '{8'h5A, 15'sd193,   1'b0, '0},
      '{8'h1E, 15'h3FFF,   1'b0, '0},
      '{8'hF0, 15'sd0,     1'b0, '0},
      '{8'hFF, 15'sd5000,  1'b0, '0},
      '{8'h55, 15'sd5000,  1'b0, '0},
      '{8'h00, 15'sd0,     1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Aim heading and open window of each waypoint leg, Q3.12 radians.
   function automatic void leg_plan(input leg_type l, output int aim, output int lo,
                                    output int hi);
      case (l)
         LEG_FIRST: begin
            aim = 4370; lo = 2048; hi = 6144;
         end
         LEG_SECOND: begin
            aim = -8741; lo = -9421; hi = -7782;
         end
         LEG_THIRD: begin
            aim = -4370; lo = -4452; hi = -4289;
         end
         default: begin
            aim = 0; lo = -193; hi = 193;
         end
      endcase
   endfunction

   task automatic predict_steering(input logic [7:0] lamps, input logic signed [14:0] head,
                                   output steer_result_t r);
      int                 lit;
      int                 aim;
      int                 lo;
      int                 hi;
      longint             wsum;
      longint             target;
      longint             h;
      longint             acc;
      logic signed [31:0] err;
      logic signed [31:0] integ;
      logic signed [31:0] out_val;
      logic [12:0]        sp;
      bit                 drive;
      lit = 0;
      wsum = 0;
      h = longint'(head);
      for (int j = 0; j < 8; j++) begin
         if (lamps[j]) begin
            lit++;
            wsum += longint'(7 - 2 * j) * longint'(lamp_pitch);
         end
      end
      if (lit == 0 || lit == 8) begin
         target = 0;
         drive = 1'b0;
      end else if (lit <= 3) begin
         target = wsum / longint'(2 * lit);
         drive = 1'b1;
      end else begin
         leg_plan(wp_leg, aim, lo, hi);
         target = longint'(aim) - h;
         if (h > lo && h < hi) wp_leg = leg_type'(2'(wp_leg + 1));
         drive = 1'b1;
      end
      // The loop error is taken against the previous output, not the heading.
      err = clamp32(target - longint'(pid_last_out));
      integ = clamp32(longint'(pid_integral) + longint'(err));
      acc = longint'(kp) * longint'(err) + longint'(ki) * longint'(integ)
          + longint'(kd) * (longint'(err) - longint'(pid_last_err));
      out_val = clamp32((acc + 2048) >>> 12);
      pid_integral = integ;
      pid_last_err = err;
      pid_last_out = out_val;
      sp = (speed_set > 13'd4096) ? 13'd4096 : speed_set;
      r.driving = drive;
      r.linear = drive ? 13'd0 - sp : 13'd0;
      r.angular = drive ? out_val : 32'sd0;
      r.leg = wp_leg;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_GAIN_P:      kp = value;
         CSR_GAIN_I:      ki = value;
         CSR_GAIN_D:      kd = value;
         CSR_LAMP_STEP:   lamp_pitch = value[12:0];
         CSR_DRIVE_SPEED: speed_set = value[12:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic program_registers(input int kind);
      logic [15:0] v [5];
      case (kind)
         0: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
         1: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4096, 16'd4096};
         // Spacing and speed above their range; the speed saturates on the output.
         2: v = '{16'd2000, 16'd300, 16'd900, 16'hFFFF, 16'hFFFF};
         3: v = '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, 16'(LAMP_STEP_RST),
                  16'(DRIVE_SPEED_RST)};
         default: v = '{16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192)),
                        16'($urandom_range(0, 8192)), 16'($urandom_range(0, 4096)),
                        16'($urandom_range(0, 4096))};
      endcase
      write_reg(CSR_GAIN_P, v[0]);
      write_reg(CSR_GAIN_I, v[1]);
      write_reg(CSR_GAIN_D, v[2]);
      write_reg(CSR_LAMP_STEP, v[3]);
      write_reg(CSR_DRIVE_SPEED, v[4]);
      // An index past the register list must leave everything untouched.
      write_reg(CSR_DRIVE_SPEED + 3'($urandom_range(1, 3)), 16'($urandom));
   endtask

   task automatic send_item(input logic [7:0] lamps, input logic [14:0] head,
                            input logic typed, input steer_result_t typed_exp);
      int            gap;
      int            sel;
      steer_result_t pred;
      @(negedge clock);
      if (burst_left == 0) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) gap = 0;
         else if (sel < 8) gap = $urandom_range(1, 10);
         else if (sel < 9) gap = $urandom_range(11, 40);
         else gap = 0;
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = (sel == 9) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
      req_if.valid <= 1'b1;
      req_if.lamp_bits <= lamps;
      req_if.heading <= head;
      burst_left--;
      do @(posedge clock); while (!req_if.ready);
      predict_steering(lamps, head, pred);
      expected_q.push_back(typed ? typed_exp : pred);
   endtask

   task automatic park_sender();
      @(negedge clock);
      req_if.valid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Waypoint-class items aim inside the window of the current leg 45 percent of
   // the time, so that the leg sequence keeps turning over.
   task automatic random_item(output logic [7:0] lamps, output logic [14:0] head);
      int         pick;
      int         aim;
      int         lo;
      int         hi;
      int         hv;
      logic [7:0] l;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         l = 8'h00;
      end else if (pick < 15) begin
         l = 8'hFF;
      end else if (pick < 50) begin
         do l = 8'($urandom); while ($countones(l) < 1 || $countones(l) > 3);
      end else begin
         do l = 8'($urandom); while ($countones(l) < 4 || $countones(l) > 7);
      end
      leg_plan(wp_leg, aim, lo, hi);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         hv = lo + 1 + int'($urandom_range(0, hi - lo - 2));
      end else if (pick < 55) begin
         case ($urandom_range(0, 3))
            0: hv = lo;
            1: hv = hi;
            2: hv = lo + 1;
            default: hv = hi - 1;
         endcase
      end else if (pick < 62) begin
         hv = ($urandom_range(0, 1) == 0) ? 16383 : -16384;
      end else begin
         hv = int'($urandom);
      end
      lamps = l;
      head = 15'(hv);
   endtask

   // Response side: stall patterns plus one long hold-off on request.
   initial begin
      int            mode;
      int            mode_left;
      int            hold_left;
      logic [15:0]   pat;
      steer_result_t exp;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      pat = '1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               $error("response transaction with no expected result");
               error_count++;
            end else begin
               exp = expected_q.pop_front();
               if (rsp_if.driving !== exp.driving) begin
                  $error("driving mismatch: expected %0d, got %0d",
                         exp.driving, rsp_if.driving);
                  error_count++;
               end
               if (rsp_if.linear_cmd !== exp.linear) begin
                  $error("linear_cmd mismatch: expected %0d, got %0d",
                         $signed(exp.linear), $signed(rsp_if.linear_cmd));
                  error_count++;
               end
               if (rsp_if.angular_cmd !== exp.angular) begin
                  $error("angular_cmd mismatch: expected %0d, got %0d",
                         exp.angular, $signed(rsp_if.angular_cmd));
                  error_count++;
               end
               if (rsp_if.waypoint_leg !== exp.leg) begin
                  $error("waypoint_leg mismatch: expected %0d, got %0d",
                         exp.leg, rsp_if.waypoint_leg);
                  error_count++;
               end
            end
         end
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(40, 300);
            pat = 16'($urandom) | 16'h0001;
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 99) < 60);
               default: begin
                  rsp_if.ready <= pat[0];
                  pat = {pat[0], pat[15:1]};
               end
            endcase
         end
      end
   end

   // Ends the run when no transaction of any kind has happened for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (csr_if.valid && csr_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0]  lamps;
      logic [14:0] head;
      int          kinds [PHASES];
      kinds = '{1, 0, 2, 4, 3, 4, 4, 1};
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.lamp_bits = '0;
      req_if.heading = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      kp = GAIN_P_RST;
      ki = GAIN_I_RST;
      kd = GAIN_D_RST;
      lamp_pitch = LAMP_STEP_RST;
      speed_set = DRIVE_SPEED_RST;
      pid_integral = '0;
      pid_last_err = '0;
      pid_last_out = '0;
      wp_leg = LEG_FIRST;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_item(dir_rows[i].lamps, dir_rows[i].head, dir_rows[i].typed, dir_rows[i].exp);
      end
      park_sender();
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         repeat (12) @(posedge clock);
         program_registers(kinds[p]);
         if (p == 2) begin
            // Long response hold-off while the sender streams without gaps.
            hold_request = 1;
            burst_left = 60;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               park_sender();
               wait_drained();
            end
            random_item(lamps, head);
            send_item(lamps, head, 1'b0, '0);
         end
         park_sender();
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
